// ===== hw/rtl/maabb_pkg.sv =====
// ----------------------------------------------------------------------------
// maabb_pkg
// Shared widths and register codes for the swept box intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package maabb_pkg;

  localparam int unsigned DATA_W    = 32;  // Q16.16 coordinate width
  localparam int unsigned TIME_W    = 17;  // Q1.16 result time, 65536 = 1.0
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_AXES  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STAT_MIN_X = 3'd0,
    REG_STAT_MIN_Y = 3'd1,
    REG_STAT_MIN_Z = 3'd2,
    REG_STAT_MAX_X = 3'd3,
    REG_STAT_MAX_Y = 3'd4,
    REG_STAT_MAX_Z = 3'd5
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== hw/rtl/maabb_if.sv =====
// ----------------------------------------------------------------------------
// maabb_if
// Valid/ready channels: query request, result, and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface maabb_req_if
  import maabb_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] mov_min_x;
  logic signed [DATA_W-1:0] mov_min_y;
  logic signed [DATA_W-1:0] mov_min_z;
  logic signed [DATA_W-1:0] mov_max_x;
  logic signed [DATA_W-1:0] mov_max_y;
  logic signed [DATA_W-1:0] mov_max_z;
  logic signed [DATA_W-1:0] move_x;
  logic signed [DATA_W-1:0] move_y;
  logic signed [DATA_W-1:0] move_z;

  modport source (
    output valid, mov_min_x, mov_min_y, mov_min_z,
    output mov_max_x, mov_max_y, mov_max_z, move_x, move_y, move_z,
    input  ready
  );
  modport sink (
    input  valid, mov_min_x, mov_min_y, mov_min_z,
    input  mov_max_x, mov_max_y, mov_max_z, move_x, move_y, move_z,
    output ready
  );
endinterface

interface maabb_rsp_if
  import maabb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [TIME_W-1:0] enter_time;

  modport source (output valid, hit, enter_time, input ready);
  modport sink   (input valid, hit, enter_time, output ready);
endinterface

interface maabb_cfg_if
  import maabb_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/maabb_slab_div.sv =====
// ----------------------------------------------------------------------------
// maabb_slab_div
// Pipelined slab time divider: (lhs - rhs) * 2^F / move, one quotient bit
// per stage, result clamped to [-1, 2^F + 1].
// ----------------------------------------------------------------------------
`default_nettype none

module maabb_slab_div
  import maabb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [DATA_W-1:0]    lhs_i,
  input  logic signed [DATA_W-1:0]    rhs_i,
  input  logic signed [DATA_W-1:0]    move_i,
  output logic signed [FRAC_BITS+2:0] time_o
);

  localparam int unsigned NS = FRAC_BITS + 2;  // abs stage, first bit, F bits
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned TW = FRAC_BITS + 3;

  logic [DATA_W-1:0] rem_q [NS];
  logic [DATA_W-1:0] dv_q  [NS];
  logic [QW-1:0]     quo_q [NS];
  logic              ovf_q [NS];
  logic              neg_q [NS];

  // stage 0: exact 33-bit difference, magnitudes, quotient sign
  logic signed [DATA_W:0] diff;
  logic [DATA_W-1:0]      dabs;
  logic [DATA_W-1:0]      mabs;

  assign diff = {lhs_i[DATA_W-1], lhs_i} - {rhs_i[DATA_W-1], rhs_i};
  assign dabs = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
  assign mabs = move_i[DATA_W-1] ? DATA_W'(-move_i) : DATA_W'(move_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= dabs;
      dv_q[0]  <= mabs;
      quo_q[0] <= '0;
      ovf_q[0] <= 1'b0;
      neg_q[0] <= diff[DATA_W] ^ move_i[DATA_W-1];
    end
  end

  // stage 1: quotient >= 2^(F+1) iff |diff| >= 2|move|; else top bit
  logic              s1_ovf;
  logic              s1_bit;
  assign s1_ovf = {1'b0, rem_q[0]} >= {dv_q[0], 1'b0};
  assign s1_bit = rem_q[0] >= dv_q[0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[1] <= s1_bit ? rem_q[0] - dv_q[0] : rem_q[0];
      dv_q[1]  <= dv_q[0];
      quo_q[1] <= {quo_q[0][QW-2:0], s1_bit};
      ovf_q[1] <= s1_ovf;
      neg_q[1] <= neg_q[0];
    end
  end

  // remaining stages: restoring step; once stage 1 sees no overflow, the remainder stays below the divisor
  for (genvar s = 2; s < NS; s++) begin : g_step
    logic [DATA_W:0] r2;
    logic            qb;
    assign r2 = {rem_q[s-1], 1'b0};
    assign qb = r2 >= {1'b0, dv_q[s-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= qb ? DATA_W'(r2 - {1'b0, dv_q[s-1]}) : r2[DATA_W-1:0];
        dv_q[s]  <= dv_q[s-1];
        quo_q[s] <= {quo_q[s-1][QW-2:0], qb};
        ovf_q[s] <= ovf_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  // clamp: anything past 1.0 acts alike, any negative time acts as -1
  logic [TW-1:0] cap;
  logic [TW-1:0] mag;
  logic [TW-1:0] time_d;
  logic [TW-1:0] time_q;

  assign cap    = (TW'(1) << FRAC_BITS) + TW'(1);
  assign mag    = (ovf_q[NS-1] || TW'(quo_q[NS-1]) > cap) ? cap : TW'(quo_q[NS-1]);
  assign time_d = (neg_q[NS-1] && mag != '0) ? '1 : mag;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      time_q <= time_d;
    end
  end

  assign time_o = $signed(time_q);

endmodule

`default_nettype wire

// ===== hw/rtl/maabb_clip.sv =====
// ----------------------------------------------------------------------------
// maabb_clip
// Orders each axis interval, intersects all three with [0, 1] and forms
// the hit flag and Q1.16 entry time. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module maabb_clip
  import maabb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [FRAC_BITS+2:0] ta_i   [NUM_AXES],
  input  logic signed [FRAC_BITS+2:0] tb_i   [NUM_AXES],
  input  logic [NUM_AXES-1:0]         still_i,
  input  logic [NUM_AXES-1:0]         sep_i,
  output logic                        hit_o,
  output logic [TIME_W-1:0]           enter_time_o
);

  localparam int unsigned TW = FRAC_BITS + 3;

  logic signed [TW-1:0] one;
  assign one = $signed(TW'(1) << FRAC_BITS);

  // stage A: per-axis ordered interval; a still axis constrains nothing
  logic signed [TW-1:0] lo_q [NUM_AXES];
  logic signed [TW-1:0] hi_q [NUM_AXES];
  logic                 fail_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (still_i[a]) begin
          lo_q[a] <= '0;
          hi_q[a] <= one;
        end else if (ta_i[a] > tb_i[a]) begin
          lo_q[a] <= tb_i[a];
          hi_q[a] <= ta_i[a];
        end else begin
          lo_q[a] <= ta_i[a];
          hi_q[a] <= tb_i[a];
        end
      end
      fail_q <= |(still_i & sep_i);
    end
  end

  // stage B: intersect and convert
  logic signed [TW-1:0]  t0;
  logic signed [TW-1:0]  t1;
  logic                  hit_d;
  logic [FRAC_BITS:0]    t0_u;
  logic [TIME_W-1:0]     conv;

  always_comb begin
    t0 = '0;
    t1 = one;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (lo_q[a] > t0) t0 = lo_q[a];
      if (hi_q[a] < t1) t1 = hi_q[a];
    end
    hit_d = !fail_q && (t0 <= t1);
  end

  assign t0_u = t0[FRAC_BITS:0];

  if (FRAC_BITS >= 16) begin : g_shr
    assign conv = TIME_W'(t0_u >> (FRAC_BITS - 16));
  end else begin : g_shl
    assign conv = TIME_W'(t0_u) << (16 - FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o        <= hit_d;
      enter_time_o <= hit_d ? conv : '0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/moving_aabb_intersection.sv =====
// ----------------------------------------------------------------------------
// moving_aabb_intersection
// Swept axis-aligned box test against a stationary box held in registers.
// ----------------------------------------------------------------------------
// One request carries a moving box and its displacement over a time step;
// one result comes back per request with a hit flag and the first contact
// time in Q1.16 (65536 = 1.0, zero on a miss). Requests are taken one per
// cycle with no gaps while the skid register is empty. Each request passes
// the six slab dividers, which produce one quotient bit per pipeline stage,
// then the clip stages and the result register. A two-entry output
// (result register plus skid register) keeps the request ready a plain
// register, so a stalled consumer halts the pipe without dropping or
// repeating anything. The stationary box is written through the register
// port (indexes 0..5: min x/y/z, max x/y/z; higher indexes are ignored)
// and must only change while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_aabb_intersection
  import maabb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  maabb_cfg_if.sink   cfg_i,
  maabb_req_if.sink   req_i,
  maabb_rsp_if.source rsp_o
);

  localparam int unsigned LAT = FRAC_BITS + 3;  // divider latency
  localparam int unsigned NST = LAT + 2;        // plus clip stages
  localparam int unsigned TW  = FRAC_BITS + 3;

  // -------- stationary box registers --------
  logic signed [DATA_W-1:0] smin_q [NUM_AXES];
  logic signed [DATA_W-1:0] smax_q [NUM_AXES];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        smin_q[a] <= '0;
        smax_q[a] <= '0;
      end
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_STAT_MIN_X: smin_q[0] <= $signed(cfg_i.data);
        REG_STAT_MIN_Y: smin_q[1] <= $signed(cfg_i.data);
        REG_STAT_MIN_Z: smin_q[2] <= $signed(cfg_i.data);
        REG_STAT_MAX_X: smax_q[0] <= $signed(cfg_i.data);
        REG_STAT_MAX_Y: smax_q[1] <= $signed(cfg_i.data);
        REG_STAT_MAX_Z: smax_q[2] <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  // -------- pipe control --------
  // Whole pipe moves together; it only halts while the skid slot is full.
  logic           en;
  logic [NST-1:0] vld_q;
  logic           skid_vld_q;

  assign en          = !skid_vld_q;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], req_i.valid};
    end
  end

  // -------- per-axis inputs --------
  logic signed [DATA_W-1:0] mmin [NUM_AXES];
  logic signed [DATA_W-1:0] mmax [NUM_AXES];
  logic signed [DATA_W-1:0] mv   [NUM_AXES];

  assign mmin[0] = req_i.mov_min_x;
  assign mmin[1] = req_i.mov_min_y;
  assign mmin[2] = req_i.mov_min_z;
  assign mmax[0] = req_i.mov_max_x;
  assign mmax[1] = req_i.mov_max_y;
  assign mmax[2] = req_i.mov_max_z;
  assign mv[0]   = req_i.move_x;
  assign mv[1]   = req_i.move_y;
  assign mv[2]   = req_i.move_z;

  // Zero displacement: the axis passes only on strict slab overlap.
  logic [NUM_AXES-1:0] still;
  logic [NUM_AXES-1:0] sep;
  logic [NUM_AXES-1:0] still_q [LAT];
  logic [NUM_AXES-1:0] sep_q   [LAT];

  logic signed [TW-1:0] ta [NUM_AXES];
  logic signed [TW-1:0] tb [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    assign still[a] = (mv[a] == '0);
    assign sep[a]   = (smin_q[a] >= mmax[a]) || (smax_q[a] <= mmin[a]);

    // entry: (smin - mmax) / move, exit: (smax - mmin) / move
    maabb_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_enter (
      .clk_i  (clk_i),
      .en_i   (en),
      .lhs_i  (smin_q[a]),
      .rhs_i  (mmax[a]),
      .move_i (mv[a]),
      .time_o (ta[a])
    );

    maabb_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_leave (
      .clk_i  (clk_i),
      .en_i   (en),
      .lhs_i  (smax_q[a]),
      .rhs_i  (mmin[a]),
      .move_i (mv[a]),
      .time_o (tb[a])
    );
  end

  // flags ride alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      still_q[0] <= still;
      sep_q[0]   <= sep;
      for (int s = 1; s < LAT; s++) begin
        still_q[s] <= still_q[s-1];
        sep_q[s]   <= sep_q[s-1];
      end
    end
  end

  // -------- interval intersection --------
  logic              p_hit;
  logic [TIME_W-1:0] p_time;

  maabb_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk_i        (clk_i),
    .en_i         (en),
    .ta_i         (ta),
    .tb_i         (tb),
    .still_i      (still_q[LAT-1]),
    .sep_i        (sep_q[LAT-1]),
    .hit_o        (p_hit),
    .enter_time_o (p_time)
  );

  // -------- result register and skid slot --------
  logic              out_vld_q;
  logic              out_hit_q;
  logic [TIME_W-1:0] out_time_q;
  logic              skid_hit_q;
  logic [TIME_W-1:0] skid_time_q;
  logic              out_free;
  logic              p_vld;

  assign out_free = !out_vld_q || rsp_o.ready;
  assign p_vld    = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q || p_vld;
      skid_vld_q <= 1'b0;
    end else if (!skid_vld_q && p_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_hit_q  <= skid_vld_q ? skid_hit_q  : p_hit;
      out_time_q <= skid_vld_q ? skid_time_q : p_time;
    end else if (!skid_vld_q) begin
      skid_hit_q  <= p_hit;
      skid_time_q <= p_time;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.enter_time = out_time_q;

  // -------- assertions --------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid slot holds a result while the output is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !rsp_o.ready && p_vld))
    else $error("skid slot filled without an output stall");

  a_tail_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && p_vld && !out_free) |=> p_vld)
    else $error("pipe tail lost while halted");

  a_miss_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_hit_q) |-> (out_time_q == '0))
    else $error("miss reported with nonzero entry time");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_time_q <= (TIME_W'(1) << 16)))
    else $error("entry time beyond 1.0");

endmodule

`default_nettype wire

// ===== verif/moving_aabb_intersection_tb.sv =====
// ----------------------------------------------------------------------------
// moving_aabb_intersection_tb
// Self-checking bench for the swept box test: directed and random requests
// against a built-in slab predictor, random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module moving_aabb_intersection_tb;
  import maabb_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned LATENCY = FRAC + 6;
  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -64'sh0000_8000_0000_0000;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
    logic signed [DATA_W-1:0] mv_x, mv_y, mv_z;
  } sweep_t;

  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] t_enter;
  } contact_t;

  logic clk_i, rst_ni;
  maabb_cfg_if cfg_if ();
  maabb_req_if req_if ();
  maabb_rsp_if rsp_if ();

  moving_aabb_intersection #(.FRAC_BITS(FRAC)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_if), .req_i(req_if), .rsp_o(rsp_if)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Local copy of the stationary box: index 0..2 min, 3..5 max
  longint   box_reg [6];
  contact_t contact_q [$];
  int       n_errors = 0;
  longint   cycles = 0;
  bit       calm = 0;   // no stalls in the last part of the run

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---- predictor ----------------------------------------------------------
  function automatic longint slab_time(longint diff, longint mv);
    longint q;
    q = (diff * (64'sd1 <<< FRAC)) / mv;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q;
  endfunction

  // Clip [t0,t1] by one axis; zero displacement needs strict slab overlap.
  function automatic bit clip_axis(longint smin, longint smax, longint mmin, longint mmax,
                                   longint mv, inout longint t0, inout longint t1);
    longint a, b, s;
    if (mv == 0) return !(smin >= mmax || smax <= mmin);
    a = slab_time(smin - mmax, mv);
    b = slab_time(smax - mmin, mv);
    if (a > b) begin
      s = a; a = b; b = s;
    end
    if (a > t0) t0 = a;
    if (b < t1) t1 = b;
    return t0 <= t1;
  endfunction

  function automatic contact_t predict_contact(sweep_t s);
    contact_t r;
    longint t0, t1;
    bit ok;
    t0 = 0;
    t1 = 64'sd1 <<< FRAC;
    ok = clip_axis(box_reg[REG_STAT_MIN_X], box_reg[REG_STAT_MAX_X], s.min_x, s.max_x,
                   s.mv_x, t0, t1);
    if (ok) ok = clip_axis(box_reg[REG_STAT_MIN_Y], box_reg[REG_STAT_MAX_Y], s.min_y,
                           s.max_y, s.mv_y, t0, t1);
    if (ok) ok = clip_axis(box_reg[REG_STAT_MIN_Z], box_reg[REG_STAT_MAX_Z], s.min_z,
                           s.max_z, s.mv_z, t0, t1);
    r.hit = ok;
    r.t_enter = ok ? TIME_W'(FRAC >= 16 ? t0 >>> (FRAC - 16) : t0 <<< (16 - FRAC)) : '0;
    return r;
  endfunction

  // ---- result side ---------------------------------------------------------
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18);
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    contact_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (contact_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b time=%0d", $time, rsp_if.hit,
                 rsp_if.enter_time);
        n_errors++;
      end else begin
        want = contact_q.pop_front();
        if (rsp_if.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_if.hit);
          n_errors++;
        end
        if (rsp_if.enter_time !== want.t_enter) begin
          $display("%0t: enter_time expected %0d actual %0d", $time, want.t_enter,
                   rsp_if.enter_time);
          n_errors++;
        end
      end
    end
  end

  // ---- request side ------------------------------------------------------
  task automatic send_sweep(sweep_t s);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    {req_if.mov_min_x, req_if.mov_min_y, req_if.mov_min_z, req_if.mov_max_x,
     req_if.mov_max_y, req_if.mov_max_z, req_if.move_x, req_if.move_y, req_if.move_z} <= s;
    req_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    contact_q.push_back(predict_contact(s));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    if (idx < 6) box_reg[idx] = longint'(signed'(val));
    @(posedge clk_i);
  endtask

  // Wait for the pipe to drain before touching registers.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic set_box(logic [DATA_W-1:0] x0, y0, z0, x1, y1, z1);
    drain();
    write_reg(REG_STAT_MIN_X, x0);
    write_reg(REG_STAT_MIN_Y, y0);
    write_reg(REG_STAT_MIN_Z, z0);
    write_reg(REG_STAT_MAX_X, x1);
    write_reg(REG_STAT_MAX_Y, y1);
    write_reg(REG_STAT_MAX_Z, z1);
  endtask

  function automatic logic [DATA_W-1:0] rnd_word();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'h8000_0000 ^ ($urandom_range(0, 3));
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    endcase
  endfunction

  // Plausible sweep near the stationary box: small sizes, moves of a few units.
  function automatic sweep_t rnd_sweep();
    sweep_t s;
    logic [DATA_W-1:0] m [3];
    logic signed [DATA_W-1:0] lo, sz;
    for (int a = 0; a < 3; a++) begin
      lo = $signed($urandom_range(0, 16 << 16)) - (8 << 16);
      sz = $urandom_range(0, 4 << 16);
      m[a] = ($urandom_range(0, 7) == 0) ? 32'h0 : $signed($urandom_range(0, 16 << 16))
             - (8 << 16);
      case (a)
        0: begin s.min_x = lo; s.max_x = lo + sz; end
        1: begin s.min_y = lo; s.max_y = lo + sz; end
        default: begin s.min_z = lo; s.max_z = lo + sz; end
      endcase
    end
    s.mv_x = m[0]; s.mv_y = m[1]; s.mv_z = m[2];
    if ($urandom_range(0, 9) == 0)
      s = {rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
           rnd_word(), rnd_word(), rnd_word()};
    return s;
  endfunction

  // ---- tests ---------------------------------------------------------------
  task automatic test_directed();
    logic signed [DATA_W-1:0] one;
    one = 32'sh1_0000;
    set_box(-one, -one, -one, one, one, one);
    // approach from left, enter at 0.5
    send_sweep('{-4*one, -one, -one, -3*one, one, one, 4*one, 0, 0});
    // already overlapping, zero move
    send_sweep('{-one, -one, -one, one, one, one, 0, 0, 0});
    // touching faces with zero move: strict overlap fails
    send_sweep('{one, -one, -one, 2*one, one, one, 0, 0, 0});
    // touching at end of the step
    send_sweep('{-4*one, -one, -one, -3*one, one, one, 2*one, 0, 0});
    // moving away
    send_sweep('{-4*one, -one, -one, -3*one, one, one, -one, 0, 0});
    // negative move from right
    send_sweep('{3*one, -one, -one, 4*one, one, one, 0, 0, -4*one});
    send_sweep('{3*one, -one, -one, 4*one, one, one, -4*one, 0, 0});
    // inverted moving box
    send_sweep('{one, one, one, -one, -one, -one, one, one, one});
    // saturation: tiny move, huge difference
    send_sweep('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, -1, 1});
    send_sweep('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh7FFF_FFFF, -1});
    send_sweep('{-one, -one, -one, one, one, one, 32'sh8000_0000, 32'sh8000_0000, 1});
    send_sweep('{'1, '1, '1, '1, '1, '1, '1, '1, '1});
    send_sweep('0);
    // extreme stationary box, then unused register index
    set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF);
    write_reg(3'd6, 32'h1234_5678);
    write_reg(3'd7, 32'hFFFF_FFFF);
    send_sweep('{-one, -one, -one, one, one, one, 0, 0, 0});
    send_sweep('{32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, one, one, 0, 0, 0});
    send_sweep('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 5, 5, 5});
  endtask

  task automatic test_random();
    logic signed [DATA_W-1:0] lo, sz;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 3) set_box(0, 0, 0, 0, 0, 0);
      else if (phase == 5) set_box(rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                                   rnd_word(), rnd_word());
      else begin
        lo = -$signed($urandom_range(0, 4 << 16));
        sz = $urandom_range(1, 6 << 16);
        set_box(lo, lo, lo, lo + sz, lo + sz, lo + sz);
      end
      if (phase == 5) calm = 1;
      for (int i = 0; i < 215; i++) send_sweep(rnd_sweep());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid <= 1'b0;
    req_if.mov_min_x <= '0; req_if.mov_min_y <= '0; req_if.mov_min_z <= '0;
    req_if.mov_max_x <= '0; req_if.mov_max_y <= '0; req_if.mov_max_z <= '0;
    req_if.move_x <= '0; req_if.move_y <= '0; req_if.move_z <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    foreach (box_reg[i]) box_reg[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    drain();
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
